FILE: hdl/c3gs_pkg.sv
package c3gs_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W = 8;
   localparam int COL_W = 11;
   localparam int ROW_W = 12;
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CFG_MODE_W   = 2;

   localparam int GAUSS_NORM_SHIFT = 4;
   localparam int SOBEL_NORM_SHIFT = 3;

   localparam int OUT_DEPTH = 8;
   localparam int OUT_IDX_W = $clog2(OUT_DEPTH);
   localparam int OUT_PTR_W = OUT_IDX_W + 1;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_MODE   = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_IDENTITY = 2'd0,
      MODE_GAUSS    = 2'd1,
      MODE_SOBEL    = 2'd2
   } filter_mode_type;

   typedef struct packed {
      logic             two;
      logic             zero;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } stage_ctl_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } result_type;

endpackage

FILE: hdl/conv3x3_gauss_sobel_filter.sv
// 3x3 image filter over a raster pixel stream.
// req channel: one grey pixel word per accepted transfer, in raster order.
// rsp channel: result words of pixel, row, column and a last flag that marks
// the final word caused by one input pixel. Interior rows give one word per
// column; columns 0 and width-1 carry zero; border rows give nothing.
// csr port: image_width at 0x0, image_height at 0x4, filter_mode at 0x8
// (0 pass, 1 gaussian, 2 and 3 sobel). Any write restarts the frame; write
// only while the block is idle.
// Throughput: one pixel per clock while req_stall is low. The two previous rows sit in two
// single-port-read banks; each pixel reads both banks and writes one at its
// column in the same cycle, so the banks set no limit. Rows end with two
// words for one pixel, so the output queue briefly runs one word ahead.
// Path: a taken pixel passes the stage 1 and stage 2 registers into the output queue.
// Stall: when rsp_stall holds, words collect in an 8-word queue; req_stall
// rises when queued plus in-flight words could overflow it.
// Reset: counters, window and queue clear; registers return to 1280 x 384,
// mode 0. The row banks are not cleared; the first two rows fill them.
module conv3x3_gauss_sobel_filter
   import c3gs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic [ROW_W-1:0]      rsp_out_row,
   output logic [COL_W-1:0]      rsp_out_col,
   output logic                  rsp_last_of_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;
   logic [CFG_MODE_W-1:0]   mode_ff;
   logic                    cfg_write;

   logic [COL_W-1:0] w_last;
   logic [ROW_W-1:0] h_last;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             req_accept;
   logic             rsp_pop;
   logic [1:0]       n_acc;
   logic             acc_emit;
   stage_ctl_type    acc_ctl;

   logic [OUT_PTR_W-1:0] credit_ff, credit_in;

   logic             wr_bank0, wr_bank1;
   logic [PIX_W-1:0] bank0_data, bank1_data;

   logic             s1_valid_ff;
   logic             s1_emit_ff;
   logic             s1_bank_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   stage_ctl_type    s1_ctl_ff;

   logic [PIX_W-1:0] win_ff [6];
   logic [PIX_W-1:0] top, mid;
   logic [9:0]       sum_row0, sum_row2, sum_col0, sum_col2;
   logic [11:0]      gsum;
   logic [10:0]      gx, gy;

   logic             s2_emit_ff;
   stage_ctl_type    s2_ctl_ff;
   logic [11:0]      s2_gsum_ff;
   logic [10:0]      s2_gx_ff, s2_gy_ff;
   logic [PIX_W-1:0] s2_center_ff;

   logic [9:0]       gx_abs, gy_abs;
   logic [10:0]      sobel_sum;
   logic [PIX_W-1:0] filt_pix;
   result_type       res0, res1;
   logic [1:0]       n_push;

   result_type           fifo_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [OUT_PTR_W-1:0] wp_next1;

   // csr port

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_WIDTH_W'(1280);
         height_ff <= CFG_HEIGHT_W'(384);
         mode_ff   <= MODE_IDENTITY;
      end else if (cfg_write) begin
         case (csr_paddr[3:2])
            REG_WIDTH:  width_ff  <= csr_pwdata[CFG_WIDTH_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[CFG_HEIGHT_W-1:0];
            REG_MODE:   mode_ff   <= csr_pwdata[CFG_MODE_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_MODE:   csr_prdata = CSR_DATA_W'(mode_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // clamped frame size

   always_comb begin
      if (width_ff < CFG_WIDTH_W'(3)) begin
         w_last = COL_W'(2);
      end else if (width_ff > CFG_WIDTH_W'(MAX_WIDTH)) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(width_ff - 1'b1);
      end
      if (height_ff < CFG_HEIGHT_W'(3)) begin
         h_last = ROW_W'(2);
      end else if (height_ff > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
         h_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(height_ff - 1'b1);
      end
   end

   // input side

   assign req_stall  = credit_ff > OUT_PTR_W'(OUT_DEPTH - 2);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_pop    = rsp_valid & ~rsp_stall;

   always_comb begin
      n_acc        = 2'd0;
      acc_ctl.two  = 1'b0;
      acc_ctl.zero = (col_ff == '0);
      acc_ctl.row  = row_ff - 1'b1;
      acc_ctl.col  = (col_ff == '0) ? '0 : col_ff - 1'b1;
      if (row_ff >= ROW_W'(2)) begin
         if (col_ff == '0) begin
            n_acc = 2'd1;
         end else if (col_ff >= COL_W'(2)) begin
            acc_ctl.two = (col_ff == w_last);
            n_acc       = acc_ctl.two ? 2'd2 : 2'd1;
         end
      end
      acc_emit = (n_acc != 2'd0);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_ff == w_last) begin
            col_in = '0;
            row_in = (row_ff == h_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign credit_in = credit_ff
                    + (req_accept ? OUT_PTR_W'(n_acc) : OUT_PTR_W'(0))
                    - OUT_PTR_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         credit_ff <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         credit_ff <= credit_in;
      end
   end

   // row banks: bank row[0] holds row r-2, the other row r-1

   assign wr_bank0 = req_accept & ~row_ff[0];
   assign wr_bank1 = req_accept & row_ff[0];

   c3gs_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_bank0),
      .wr_addr (col_ff),
      .wr_data (req_pixel_in),
      .rd_addr (col_ff),
      .rd_data (bank0_data)
   );

   c3gs_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_bank1),
      .wr_addr (col_ff),
      .wr_data (req_pixel_in),
      .rd_addr (col_ff),
      .rd_data (bank1_data)
   );

   // stage 1: window and partial sums

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         s1_emit_ff  <= req_accept & acc_emit;
      end
   end

   always_ff @(posedge clock) begin
      s1_bank_ff <= row_ff[0];
      s1_pix_ff  <= req_pixel_in;
      s1_ctl_ff  <= acc_ctl;
   end

   assign top = s1_bank_ff ? bank1_data : bank0_data;
   assign mid = s1_bank_ff ? bank0_data : bank1_data;

   always_ff @(posedge clock) begin
      if (reset || cfg_write) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= s1_pix_ff;
      end
   end

   // window columns: 0,1,2 left; 3,4,5 middle; top, mid, pixel right
   always_comb begin
      sum_row0 = 10'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + 10'(top);
      sum_row2 = 10'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + 10'(s1_pix_ff);
      sum_col0 = 10'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + 10'(win_ff[2]);
      sum_col2 = 10'(top) + {1'b0, mid, 1'b0} + 10'(s1_pix_ff);
      gsum     = 12'(sum_row0) + 12'(sum_row2)
               + {3'b0, win_ff[1], 1'b0} + {2'b0, win_ff[4], 2'b0}
               + {3'b0, mid, 1'b0};
      gx       = {1'b0, sum_row0} - {1'b0, sum_row2};
      gy       = {1'b0, sum_col0} - {1'b0, sum_col2};
   end

   // stage 2: finish filter, push words

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else begin
         s2_emit_ff <= s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_ctl_ff    <= s1_ctl_ff;
      s2_gsum_ff   <= gsum;
      s2_gx_ff     <= gx;
      s2_gy_ff     <= gy;
      s2_center_ff <= win_ff[4];
   end

   always_comb begin
      gx_abs    = s2_gx_ff[10] ? 10'(-s2_gx_ff) : s2_gx_ff[9:0];
      gy_abs    = s2_gy_ff[10] ? 10'(-s2_gy_ff) : s2_gy_ff[9:0];
      sobel_sum = 11'(gx_abs) + 11'(gy_abs);
      case (mode_ff)
         MODE_IDENTITY: filt_pix = s2_center_ff;
         MODE_GAUSS:    filt_pix = PIX_W'(s2_gsum_ff >> GAUSS_NORM_SHIFT);
         default:       filt_pix = PIX_W'(sobel_sum >> SOBEL_NORM_SHIFT);
      endcase
   end

   always_comb begin
      res0.pixel = s2_ctl_ff.zero ? '0 : filt_pix;
      res0.row   = s2_ctl_ff.row;
      res0.col   = s2_ctl_ff.col;
      res0.last  = ~s2_ctl_ff.two;
      res1.pixel = '0;
      res1.row   = s2_ctl_ff.row;
      res1.col   = s2_ctl_ff.col + 1'b1;
      res1.last  = 1'b1;
      if (!s2_emit_ff) begin
         n_push = 2'd0;
      end else if (s2_ctl_ff.two) begin
         n_push = 2'd2;
      end else begin
         n_push = 2'd1;
      end
   end

   // output queue

   assign wp_next1 = wp_ff + 1'b1;
   assign wp_in    = wp_ff + OUT_PTR_W'(n_push);
   assign rp_in    = rp_ff + OUT_PTR_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_emit_ff) begin
         fifo_ff[wp_ff[OUT_IDX_W-1:0]] <= res0;
         if (s2_ctl_ff.two) begin
            fifo_ff[wp_next1[OUT_IDX_W-1:0]] <= res1;
         end
      end
   end

   assign rsp_valid        = (wp_ff != rp_ff);
   assign rsp_pixel_out    = fifo_ff[rp_ff[OUT_IDX_W-1:0]].pixel;
   assign rsp_out_row      = fifo_ff[rp_ff[OUT_IDX_W-1:0]].row;
   assign rsp_out_col      = fifo_ff[rp_ff[OUT_IDX_W-1:0]].col;
   assign rsp_last_of_item = fifo_ff[rp_ff[OUT_IDX_W-1:0]].last;

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= OUT_PTR_W'(OUT_DEPTH))
      else $error("word credit above queue depth");

   a_queue_covered: assert property (@(posedge clock) disable iff (reset)
      OUT_PTR_W'(wp_ff - rp_ff) <= credit_ff)
      else $error("queue holds more words than were reserved");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last)
      else $error("column counter past row end");

   a_two_at_row_end: assert property (@(posedge clock) disable iff (reset)
      s2_emit_ff && s2_ctl_ff.two |-> s2_ctl_ff.col == w_last - 1'b1)
      else $error("double word away from the last column");
`endif

endmodule

FILE: hdl/c3gs_ram.sv
module c3gs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: dv/c3gs_checker.sv
`timescale 1ns / 1ps
module c3gs_checker
   import c3gs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [PIX_W-1:0]      rsp_pixel_out,
   input  logic [ROW_W-1:0]      rsp_out_row,
   input  logic [COL_W-1:0]      rsp_out_col,
   input  logic                  rsp_last_of_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    pending,
   output int                    checked
);

   logic [PIX_W-1:0]        line_mem [0:2*MAX_WIDTH-1];
   logic [PIX_W-1:0]        win_cols [0:5];
   int unsigned             row_cnt;
   int unsigned             col_cnt;
   logic [CFG_WIDTH_W-1:0]  width_reg;
   logic [CFG_HEIGHT_W-1:0] height_reg;
   logic [CFG_MODE_W-1:0]   mode_reg;
   result_type              expected_pixels [$];

   function automatic int unsigned size_in_use(input int unsigned v, input int unsigned hi);
      return (v < 3) ? 3 : ((v > hi) ? hi : v);
   endfunction

   // p[3*row+col], rows top to bottom, columns left to right
   function automatic logic [PIX_W-1:0] filter_pixels(input logic [8:0][PIX_W-1:0] p,
                                                      input logic [CFG_MODE_W-1:0] mode);
      int s;
      int gx;
      int gy;
      if (mode == MODE_IDENTITY) return p[4];
      if (mode == MODE_GAUSS) begin
         s = p[0] + 2 * p[1] + p[2] + 2 * p[3] + 4 * p[4] + 2 * p[5]
           + p[6] + 2 * p[7] + p[8];
         return PIX_W'(s >> GAUSS_NORM_SHIFT);
      end
      gx = int'(p[0] + 2 * p[1] + p[2]) - int'(p[6] + 2 * p[7] + p[8]);
      gy = int'(p[0] + 2 * p[3] + p[6]) - int'(p[2] + 2 * p[5] + p[8]);
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      return PIX_W'((gx + gy) >> SOBEL_NORM_SHIFT);
   endfunction

   task automatic restart_frame();
      for (int i = 0; i < 6; i++) win_cols[i] = '0;
      row_cnt = 0;
      col_cnt = 0;
   endtask

   task automatic apply_config(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      case (index)
         REG_WIDTH:  width_reg = value[CFG_WIDTH_W-1:0];
         REG_HEIGHT: height_reg = value[CFG_HEIGHT_W-1:0];
         REG_MODE:   mode_reg = value[CFG_MODE_W-1:0];
         default: ;
      endcase
      restart_frame();
   endtask

   task automatic predict_pixel(input logic [PIX_W-1:0] pix);
      int unsigned           w;
      int unsigned           h;
      int unsigned           older;
      int unsigned           newer;
      logic [PIX_W-1:0]      top_px;
      logic [PIX_W-1:0]      mid_px;
      logic [8:0][PIX_W-1:0] p;
      result_type            res;
      w = size_in_use(width_reg, MAX_WIDTH);
      h = size_in_use(height_reg, MAX_HEIGHT);
      older = (row_cnt & 1) * MAX_WIDTH + col_cnt;
      newer = ((row_cnt + 1) & 1) * MAX_WIDTH + col_cnt;
      top_px = line_mem[older];
      mid_px = line_mem[newer];
      if (row_cnt >= 2) begin
         res.row = ROW_W'(row_cnt - 1);
         if (col_cnt == 0) begin
            res.pixel = '0;
            res.col = '0;
            res.last = 1'b1;
            expected_pixels.push_back(res);
         end else if (col_cnt >= 2) begin
            p[0] = win_cols[0];
            p[3] = win_cols[1];
            p[6] = win_cols[2];
            p[1] = win_cols[3];
            p[4] = win_cols[4];
            p[7] = win_cols[5];
            p[2] = top_px;
            p[5] = mid_px;
            p[8] = pix;
            res.pixel = filter_pixels(p, mode_reg);
            res.col = COL_W'(col_cnt - 1);
            res.last = (col_cnt != w - 1);
            expected_pixels.push_back(res);
            if (col_cnt == w - 1) begin
               res.pixel = '0;
               res.col = COL_W'(col_cnt);
               res.last = 1'b1;
               expected_pixels.push_back(res);
            end
         end
      end
      line_mem[older] = pix;
      win_cols[0] = win_cols[3];
      win_cols[1] = win_cols[4];
      win_cols[2] = win_cols[5];
      win_cols[3] = top_px;
      win_cols[4] = mid_px;
      win_cols[5] = pix;
      col_cnt++;
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt++;
         if (row_cnt >= h) row_cnt = 0;
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         for (int i = 0; i < 2 * MAX_WIDTH; i++) line_mem[i] = '0;
         restart_frame();
         width_reg = CFG_WIDTH_W'(1280);
         height_reg = CFG_HEIGHT_W'(384);
         mode_reg = MODE_IDENTITY;
         expected_pixels.delete();
         mismatches = 0;
         checked = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            apply_config(csr_paddr[CSR_ADDR_W-1:2], csr_pwdata);
         if (req_valid && !req_stall)
            predict_pixel(req_pixel_in);
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display({"%0t unexpected result word: expected none, ",
                         "actual pixel %0d row %0d col %0d last %0d"},
                        $time, rsp_pixel_out, rsp_out_row, rsp_out_col, rsp_last_of_item);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               compare_field("pixel_out", want.pixel, rsp_pixel_out);
               compare_field("out_row", want.row, rsp_out_row);
               compare_field("out_col", want.col, rsp_out_col);
               compare_field("last_of_item", want.last, rsp_last_of_item);
               checked++;
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

FILE: dv/tb_conv3x3_gauss_sobel_filter.sv
`timescale 1ns / 1ps
module tb_conv3x3_gauss_sobel_filter;
   import c3gs_pkg::*;

   localparam logic [1:0]            REG_SPARE     = 2'd3;
   localparam logic [CFG_MODE_W-1:0] MODE_SPARE    = 2'd3;
   localparam int                    QUIET_LIMIT   = 4000;
   localparam int                    SETTLE_CYCLES = 8;
   localparam int                    RANDOM_ITEMS  = 1250;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic [ROW_W-1:0]      rsp_out_row;
   logic [COL_W-1:0]      rsp_out_col;
   logic                  rsp_last_of_item;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatches;
   int pending;
   int checked;
   int sent = 0;
   int configs = 0;
   int burst_left = 0;
   int gap_max = 0;
   int pixel_style = 0;
   int quiet = 0;

   conv3x3_gauss_sobel_filter dut (.*);

   c3gs_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver stall pattern, independent of the sender
   initial begin
      int   style;
      int   style_left;
      int   run_left;
      logic hold;
      rsp_stall = 1'b0;
      style = 0;
      style_left = 0;
      run_left = 0;
      hold = 1'b0;
      forever begin
         @(negedge clock);
         if (style_left == 0) begin
            style = $urandom_range(0, 3);
            style_left = $urandom_range(40, 400);
         end
         style_left--;
         case (style)
            0: hold = 1'b0;
            1: hold = ($urandom_range(0, 3) == 0);
            2: hold = ($urandom_range(0, 3) != 0);
            default: begin
               if (run_left <= 0) begin
                  hold = !hold;
                  run_left = hold ? $urandom_range(5, 30) : $urandom_range(1, 10);
               end
               run_left--;
            end
         endcase
         rsp_stall <= hold;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("%0t watchdog: no word moved for %0d cycles, %0d results outstanding",
                  $time, quiet, pending);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic int size_in_use(input int v, input int hi);
      return (v < 3) ? 3 : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [PIX_W-1:0] rand_pixel();
      case (pixel_style)
         1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         2: return PIX_W'($urandom_range(100, 140));
         3: begin
            case ($urandom_range(0, 2))
               0: return 8'h00;
               1: return 8'hFF;
               default: return PIX_W'($urandom);
            endcase
         end
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // all tasks below start and end at a falling edge
   task automatic feed_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      if (burst_left <= 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [CFG_WIDTH_W-1:0] wreg,
                            input logic [CFG_HEIGHT_W-1:0] hreg,
                            input logic [CFG_MODE_W-1:0] mode);
      logic [CSR_DATA_W-1:0] junk;
      settle();
      junk = $urandom;
      csr_write(REG_WIDTH, {junk[31:CFG_WIDTH_W], wreg});
      csr_write(REG_HEIGHT, {junk[31:CFG_HEIGHT_W], hreg});
      csr_write(REG_MODE, {junk[31:CFG_MODE_W], mode});
      configs++;
   endtask

   task automatic feed_block(input logic [0:8][PIX_W-1:0] px);
      for (int i = 0; i < 9; i++) feed_pixel(px[i]);
   endtask

   task automatic run_phase(input logic [CFG_WIDTH_W-1:0] wreg,
                            input logic [CFG_HEIGHT_W-1:0] hreg,
                            input logic [CFG_MODE_W-1:0] mode,
                            input int n, input int drain_at);
      configure(wreg, hreg, mode);
      for (int i = 0; i < n; i++) begin
         if (i == drain_at) drain();
         feed_pixel(rand_pixel());
      end
   endtask

   initial begin
      int                      w;
      int                      h;
      int                      n;
      int                      pick;
      int                      drain_at;
      int                      target;
      logic [CFG_WIDTH_W-1:0]  wreg;
      logic [CFG_HEIGHT_W-1:0] hreg;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_in = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // clamped sizes, full-scale gaussian
      gap_max = 4;
      configure(CFG_WIDTH_W'(2), CFG_HEIGHT_W'(0), MODE_GAUSS);
      feed_block({9{8'hFF}});

      // unused mode acts as sobel; unused register index restarts the frame
      configure(CFG_WIDTH_W'(3), CFG_HEIGHT_W'(3), MODE_SPARE);
      for (int i = 0; i < 4; i++) feed_pixel(PIX_W'($urandom));
      settle();
      csr_write(REG_SPARE, $urandom);
      feed_block({8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});

      // small random frames, every mode, runs that mostly end part way through a frame
      target = sent + RANDOM_ITEMS;
      while (sent < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 2) wreg = CFG_WIDTH_W'($urandom_range(0, 2));
         else if (pick < 4) wreg = CFG_WIDTH_W'($urandom_range(25, 80));
         else wreg = CFG_WIDTH_W'($urandom_range(3, 24));
         pick = $urandom_range(0, 19);
         hreg = (pick < 3) ? CFG_HEIGHT_W'($urandom_range(0, 2))
                           : CFG_HEIGHT_W'($urandom_range(3, 8));
         w = size_in_use(wreg, MAX_WIDTH);
         h = size_in_use(hreg, MAX_HEIGHT);
         n = w * h * $urandom_range(1, 3) + $urandom_range(0, w * h - 1);
         if (n > target - sent) n = target - sent;
         case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 4;
            default: gap_max = 15;
         endcase
         pixel_style = $urandom_range(0, 3);
         drain_at = (configs == 2 || $urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
         run_phase(wreg, hreg, CFG_MODE_W'($urandom_range(0, 3)), n, drain_at);
      end

      settle();
      $display("covered %0d settings (small and clamped sizes, modes 0 to 3), %0d pixel words",
               configs, sent);
      $display("checked %0d result words under random sender gaps and receiver stalls", checked);
      if (mismatches == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
